### src/cws_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the window size constraint pipeline.
// No dependencies.
package cws_pkg;

  localparam int HALF_W = 16;            // one half of a packed size register
  localparam int XW = 34;                // working width of a side, signed
  localparam int CFG_W = 32;
  localparam int IDX_W = 3;
  localparam int COORD_BITS_DEF = 16;

  localparam int CTRL_HINTS = 0;
  localparam int CTRL_ASPECT = 1;
  localparam int CTRL_LIMIT = 2;

  localparam logic [2:0] RST_CTRL = 3'd5;
  localparam logic [CFG_W-1:0] RST_MIN_SIZE = 32'h0001_0001;
  localparam logic [CFG_W-1:0] RST_MAX_SIZE = 32'h7FFF_7FFF;
  localparam logic [CFG_W-1:0] RST_BASE_SIZE = 32'h0000_0000;
  localparam logic [CFG_W-1:0] RST_SIZE_INC = 32'h0001_0001;
  localparam logic [CFG_W-1:0] RST_ASPECT = 32'h0001_0001;

  typedef enum logic [IDX_W-1:0] {
    CFG_CONTROL    = 3'd0,
    CFG_MIN_SIZE   = 3'd1,
    CFG_MAX_SIZE   = 3'd2,
    CFG_BASE_SIZE  = 3'd3,
    CFG_SIZE_INC   = 3'd4,
    CFG_MIN_ASPECT = 3'd5,
    CFG_MAX_ASPECT = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0]       ctrl;
    logic [CFG_W-1:0] min_size;
    logic [CFG_W-1:0] max_size;
    logic [CFG_W-1:0] base_size;
    logic [CFG_W-1:0] size_inc;
    logic [CFG_W-1:0] ratio_lo;
    logic [CFG_W-1:0] ratio_hi;
  } cfg_t;

  // one request in flight
  typedef struct packed {
    logic signed [XW-1:0]     w;
    logic signed [XW-1:0]     h;
    logic signed [HALF_W-1:0] w0;
    logic signed [HALF_W-1:0] h0;
    logic                     keep;
    logic                     rnd;
    logic [14:0]              lw;
    logic [14:0]              lh;
  } item_t;

  typedef struct packed {
    item_t itm;
    logic  apply;
    logic  neg;
  } asp_side_t;

  typedef struct packed {
    item_t             itm;
    logic              apply;
    logic [HALF_W-1:0] b;
  } asp_mid_t;

  typedef struct packed {
    item_t itm;
    logic  neg;
  } snap_side_t;

endpackage

### src/cws_ifs.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the window size pipeline.
// No dependencies.
interface cws_req_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] req_width;
  logic signed [15:0] req_height;
  logic               keep_x;
  logic               round_nearest;
  logic [14:0]        limit_width;
  logic [14:0]        limit_height;

  modport source (output valid, req_width, req_height, keep_x, round_nearest,
                  limit_width, limit_height, input ready);
  modport sink (input valid, req_width, req_height, keep_x, round_nearest,
                limit_width, limit_height, output ready);
endinterface

interface cws_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_width;
  logic [15:0] out_height;

  modport source (output valid, out_width, out_height, input ready);
  modport sink (input valid, out_width, out_height, output ready);
endinterface

### src/cws_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, 16-bit divisor.
// Quotient saturates to all ones when it does not fit. Uses cws_pkg.
module cws_div #(
  parameter int NW = 32,
  parameter int QW = 32,
  parameter int SW = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [NW-1:0]             num,
  input  logic [cws_pkg::HALF_W-1:0] den,
  input  logic [SW-1:0]             in_side,
  output logic                      out_valid,
  output logic [QW-1:0]             quo,
  output logic [SW-1:0]             out_side
);
  localparam int RW = cws_pkg::HALF_W;

  logic          vld [QW];
  logic          ovf [QW];
  logic [RW-1:0] rem [QW];
  logic [RW-1:0] dv  [QW];
  logic [QW-1:0] acc [QW];
  logic [SW-1:0] sd  [QW];

  logic [NW-1:0] num_hi;
  logic          ovf_in;

  assign num_hi = num >> QW;
  assign ovf_in = num_hi >= {{(NW-RW){1'b0}}, den};

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic          s_vld, s_ovf, ge;
    logic [RW-1:0] s_rem, s_den;
    logic [QW-1:0] s_acc;
    logic [SW-1:0] s_side;
    logic [RW:0]   r2;

    if (i == 0) begin : g_first
      assign s_vld  = in_valid;
      assign s_ovf  = ovf_in;
      assign s_rem  = num_hi[RW-1:0];
      assign s_den  = den;
      assign s_acc  = num[QW-1:0];
      assign s_side = in_side;
    end else begin : g_next
      assign s_vld  = vld[i-1];
      assign s_ovf  = ovf[i-1];
      assign s_rem  = rem[i-1];
      assign s_den  = dv[i-1];
      assign s_acc  = acc[i-1];
      assign s_side = sd[i-1];
    end

    assign r2 = {s_rem, s_acc[QW-1]};
    assign ge = r2 >= {1'b0, s_den};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= s_vld;
      end
      if (en) begin
        ovf[i] <= s_ovf;
        rem[i] <= ge ? RW'(r2 - {1'b0, s_den}) : r2[RW-1:0];
        dv[i]  <= s_den;
        acc[i] <= {s_acc[QW-2:0], ge};
        sd[i]  <= s_side;
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign quo       = ovf[QW-1] ? '1 : acc[QW-1];
  assign out_side  = sd[QW-1];
endmodule

### src/cws_aspect.sv
`timescale 1ns / 1ps
// One aspect ratio correction (minimum or maximum) as a pipeline:
// products, compare, first divide and clamp, second divide. Uses cws_pkg, cws_div.
module cws_aspect #(
  parameter bit IS_MAX = 1'b0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  cws_pkg::cfg_t  cfg,
  input  logic           in_valid,
  input  cws_pkg::item_t in_item,
  output logic           out_valid,
  output cws_pkg::item_t out_item
);
  localparam int PW  = 51;   // full x*h product, signed
  localparam int NW1 = 50;
  localparam int QW1 = 17;   // clamped afterwards, so 17 bits is plenty
  localparam int HW  = cws_pkg::HALF_W;

  logic [HW-1:0] ax, ay, wm, hm, wmx, hmx;
  logic          active;

  assign ax     = IS_MAX ? cfg.ratio_hi[HW-1:0] : cfg.ratio_lo[HW-1:0];
  assign ay     = IS_MAX ? cfg.ratio_hi[2*HW-1:HW] : cfg.ratio_lo[2*HW-1:HW];
  assign wm     = cfg.min_size[HW-1:0];
  assign hm     = cfg.min_size[2*HW-1:HW];
  assign wmx    = cfg.max_size[HW-1:0];
  assign hmx    = cfg.max_size[2*HW-1:HW];
  assign active = cfg.ctrl[cws_pkg::CTRL_HINTS] & cfg.ctrl[cws_pkg::CTRL_ASPECT];

  // stage 1: partial products
  logic                v1;
  cws_pkg::item_t      i1;
  logic signed [33:0]  xh_hi, yw_hi;
  logic [32:0]         xh_lo, yw_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      i1    <= in_item;
      xh_hi <= $signed(in_item.h[33:17]) * $signed({1'b0, ax});
      xh_lo <= in_item.h[16:0] * ax;
      yw_hi <= $signed(in_item.w[33:17]) * $signed({1'b0, ay});
      yw_lo <= in_item.w[16:0] * ay;
    end
  end

  // stage 2: sum partial products
  logic                v2;
  cws_pkg::item_t      i2;
  logic signed [PW-1:0] pxh, pyw, xh_ext, yw_ext;

  assign xh_ext = PW'(xh_hi);
  assign yw_ext = PW'(yw_hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      i2  <= i1;
      pxh <= (xh_ext <<< 17) + $signed({{(PW-33){1'b0}}, xh_lo});
      pyw <= (yw_ext <<< 17) + $signed({{(PW-33){1'b0}}, yw_lo});
    end
  end

  // stage 3: compare, pick numerator
  logic                 v3;
  cws_pkg::asp_side_t   s3;
  logic [NW1-1:0]       mag1;
  logic [HW-1:0]        d1;
  logic signed [PW-1:0] n1;
  logic                 cond;

  assign n1   = i2.keep ? pyw : pxh;
  assign cond = IS_MAX ? (pxh < pyw) : (pxh > pyw);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      s3.itm   <= i2;
      s3.apply <= active & cond;
      s3.neg   <= n1[PW-1];
      mag1     <= n1[PW-1] ? NW1'(-n1) : NW1'(n1);
      d1       <= i2.keep ? ax : ay;
    end
  end

  logic                        dv1_valid;
  logic [QW1-1:0]              q1;
  logic [$bits(cws_pkg::asp_side_t)-1:0] dv1_side;
  cws_pkg::asp_side_t          s4in;

  cws_div #(.NW(NW1), .QW(QW1), .SW($bits(cws_pkg::asp_side_t))) u_div1 (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v3), .num(mag1), .den(d1), .in_side(s3),
    .out_valid(dv1_valid), .quo(q1), .out_side(dv1_side)
  );
  assign s4in = cws_pkg::asp_side_t'(dv1_side);

  // stage 4: sign, zero divisor, clamp to the size limits
  logic               k4, hl4;
  logic [HW-1:0]      lo4, hi4, dd4;
  logic signed [18:0] qs, cl;

  assign k4  = s4in.itm.keep;
  assign dd4 = k4 ? ax : ay;
  assign lo4 = k4 ? hm : wm;
  assign hi4 = k4 ? hmx : wmx;
  assign hl4 = IS_MAX && k4;   // keep-width max correction applies the minimum last

  always_comb begin
    if (dd4 == '0) begin
      qs = $signed({3'b0, hi4});
    end else if (s4in.neg) begin
      qs = -$signed({2'b0, q1});
    end else begin
      qs = $signed({2'b0, q1});
    end
    cl = qs;
    if (hl4) begin
      if (cl > $signed({3'b0, hi4})) cl = $signed({3'b0, hi4});
      if (cl < $signed({3'b0, lo4})) cl = $signed({3'b0, lo4});
    end else begin
      if (cl < $signed({3'b0, lo4})) cl = $signed({3'b0, lo4});
      if (cl > $signed({3'b0, hi4})) cl = $signed({3'b0, hi4});
    end
  end

  logic              v4;
  cws_pkg::asp_mid_t m4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= dv1_valid;
    end
    if (en) begin
      m4.itm   <= s4in.itm;
      m4.apply <= s4in.apply;
      m4.b     <= cl[HW-1:0];
    end
  end

  // stage 5: second product
  logic              v5;
  cws_pkg::asp_mid_t m5;
  logic [2*HW-1:0]   n2;
  logic [HW-1:0]     d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
    if (en) begin
      m5 <= m4;
      n2 <= m4.b * (m4.itm.keep ? ax : ay);
    end
  end

  assign d2 = m5.itm.keep ? ay : ax;

  logic                                 dv2_valid;
  logic [2*HW-1:0]                      q2;
  logic [$bits(cws_pkg::asp_mid_t)-1:0] dv2_side;
  cws_pkg::asp_mid_t                    m6;

  cws_div #(.NW(2*HW), .QW(2*HW), .SW($bits(cws_pkg::asp_mid_t))) u_div2 (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v5), .num(n2), .den(d2), .in_side(m5),
    .out_valid(dv2_valid), .quo(q2), .out_side(dv2_side)
  );
  assign m6 = cws_pkg::asp_mid_t'(dv2_side);

  // stage 6: write back the corrected pair
  logic                            k6;
  logic [HW-1:0]                   dd6;
  logic signed [cws_pkg::XW-1:0]   q2s, bs;
  cws_pkg::item_t                  o6;

  assign k6  = m6.itm.keep;
  assign dd6 = k6 ? ay : ax;
  assign bs  = $signed({{(cws_pkg::XW-HW){1'b0}}, m6.b});

  always_comb begin
    if (dd6 == '0) begin
      q2s = $signed({{(cws_pkg::XW-HW){1'b0}}, (k6 ? wmx : hmx)});
    end else begin
      q2s = $signed({{(cws_pkg::XW-2*HW){1'b0}}, q2});
    end
    o6 = m6.itm;
    if (m6.apply) begin
      if (k6) begin
        o6.h = bs;
        o6.w = q2s;
      end else begin
        o6.w = bs;
        o6.h = q2s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv2_valid;
    end
    if (en) begin
      out_item <= o6;
    end
  end
endmodule

### src/cws_snap.sv
`timescale 1ns / 1ps
// Size clamp, screen limit, snap to base plus increment and final floor of 1.
// Ends in the response register. Uses cws_pkg, cws_div.
module cws_snap #(
  parameter int COORD_BITS = cws_pkg::COORD_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  cws_pkg::cfg_t  cfg,
  input  logic           in_valid,
  input  cws_pkg::item_t in_item,
  output logic           out_valid,
  output logic [15:0]    out_width,
  output logic [15:0]    out_height
);
  localparam int HW  = cws_pkg::HALF_W;
  localparam int XW  = cws_pkg::XW;
  localparam int CAP = (COORD_BITS >= 16) ? 65535 : ((1 << COORD_BITS) - 1);
  localparam logic signed [35:0] CAP_S = 36'(CAP);

  function automatic logic [HW-1:0] clamp_lh(input logic signed [XW-1:0] v,
                                             input logic [HW-1:0] lo,
                                             input logic [HW-1:0] hi);
    logic signed [XW-1:0] t;
    t = v;
    if (t < $signed({{(XW-HW){1'b0}}, lo})) t = $signed({{(XW-HW){1'b0}}, lo});
    if (t > $signed({{(XW-HW){1'b0}}, hi})) t = $signed({{(XW-HW){1'b0}}, hi});
    return t[HW-1:0];
  endfunction

  logic          hints, lim_on;
  logic [HW-1:0] inc_w, inc_h, bw, bh;

  assign hints  = cfg.ctrl[cws_pkg::CTRL_HINTS];
  assign lim_on = cfg.ctrl[cws_pkg::CTRL_LIMIT];
  assign inc_w  = (cfg.size_inc[HW-1:0] == '0) ? HW'(1) : cfg.size_inc[HW-1:0];
  assign inc_h  = (cfg.size_inc[2*HW-1:HW] == '0) ? HW'(1) : cfg.size_inc[2*HW-1:HW];
  assign bw     = cfg.base_size[HW-1:0];
  assign bh     = cfg.base_size[2*HW-1:HW];

  // stage 1: clamp, limit, offset from base
  logic [HW-1:0]    cw, ch;
  logic signed [17:0] tw, th;

  always_comb begin
    cw = clamp_lh(in_item.w, cfg.min_size[HW-1:0], cfg.max_size[HW-1:0]);
    ch = clamp_lh(in_item.h, cfg.min_size[2*HW-1:HW], cfg.max_size[2*HW-1:HW]);
    if (lim_on && (cw >= {1'b0, in_item.lw})) cw = {1'b0, in_item.lw};
    if (lim_on && (ch >= {1'b0, in_item.lh})) ch = {1'b0, in_item.lh};
    tw = $signed({2'b0, cw}) - $signed({2'b0, bw})
       + $signed({2'b0, (in_item.rnd ? (inc_w >> 1) : HW'(0))});
    th = $signed({2'b0, ch}) - $signed({2'b0, bh})
       + $signed({2'b0, (in_item.rnd ? (inc_h >> 1) : HW'(0))});
  end

  logic                v1;
  cws_pkg::snap_side_t sw1;
  logic                neg_h1;
  logic [16:0]         mw1, mh1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      sw1.itm <= in_item;
      sw1.neg <= tw[17];
      neg_h1  <= th[17];
      mw1     <= tw[17] ? 17'(-tw) : 17'(tw);
      mh1     <= th[17] ? 17'(-th) : 17'(th);
    end
  end

  logic                                   vw, vh;
  logic [16:0]                            qw, qh;
  logic [$bits(cws_pkg::snap_side_t)-1:0] sw_raw;
  logic                                   neg_h2;
  cws_pkg::snap_side_t                    sw2;

  cws_div #(.NW(17), .QW(17), .SW($bits(cws_pkg::snap_side_t))) u_div_w (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v1), .num(mw1), .den(inc_w), .in_side(sw1),
    .out_valid(vw), .quo(qw), .out_side(sw_raw)
  );

  cws_div #(.NW(17), .QW(17), .SW(1)) u_div_h (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v1), .num(mh1), .den(inc_h), .in_side(neg_h1),
    .out_valid(vh), .quo(qh), .out_side(neg_h2)
  );
  assign sw2 = cws_pkg::snap_side_t'(sw_raw);

  // stage 3: signed quotient times step
  logic signed [17:0] qsw, qsh;
  assign qsw = sw2.neg ? -$signed({1'b0, qw}) : $signed({1'b0, qw});
  assign qsh = neg_h2 ? -$signed({1'b0, qh}) : $signed({1'b0, qh});

  logic               v3;
  cws_pkg::item_t     i3;
  logic signed [34:0] pw, ph;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= vw & vh;
    end
    if (en) begin
      i3 <= sw2.itm;
      pw <= qsw * $signed({1'b0, inc_w});
      ph <= qsh * $signed({1'b0, inc_h});
    end
  end

  // stage 4: add base, saturate, floor at 1
  logic signed [35:0] fw, fh;
  logic [15:0]        rw, rh;

  always_comb begin
    fw = hints ? ($signed({20'b0, bw}) + 36'(pw)) : 36'(i3.w0);
    fh = hints ? ($signed({20'b0, bh}) + 36'(ph)) : 36'(i3.h0);
    if (fw > CAP_S) begin
      rw = 16'(CAP);
    end else if (fw <= 36'sd0) begin
      rw = 16'd1;
    end else begin
      rw = fw[15:0];
    end
    if (fh > CAP_S) begin
      rh = 16'(CAP);
    end else if (fh <= 36'sd0) begin
      rh = 16'd1;
    end else begin
      rh = fh[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v3;
    end
    if (en) begin
      out_width  <= rw;
      out_height <= rh;
    end
  end
endmodule

### src/constrain_window_size_top.sv
`timescale 1ns / 1ps
// Window size constraint against size hints: configuration registers,
// two aspect corrections and the snap stage. Uses cws_pkg, cws_ifs, submodules.
//
// Usage:
//   req  : valid/ready channel with requested width/height, keep_x,
//          round_nearest and the layer's screen limit.
//   rsp  : valid/ready channel with out_width/out_height, one beat per
//          request beat, in order.
//   cfg  : cfg_we/cfg_index/cfg_data write port; write only while idle.
// Throughput: one beat per cycle when not stalled, fully pipelined.
// Pipeline depth: set by the chain of bit-per-stage dividers between request
//   beat and response beat: two 17-stage and two 32-stage ones in the aspect
//   corrections, one 17-stage pair in the snap, plus 15 register stages.
// Stall: the whole pipeline holds while a response waits and rsp.ready is low;
//   req.ready drops in the same cycle, nothing is lost or repeated.
// Reset (rst, synchronous): pipeline empties and the registers return to
//   hints on, aspect off, screen limit on, 1..32767 size, step 1, base 0.
module constrain_window_size_top #(
  parameter int COORD_BITS = cws_pkg::COORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [cws_pkg::IDX_W-1:0]   cfg_index,
  input  logic [cws_pkg::CFG_W-1:0]   cfg_data,
  cws_req_if.sink                     req,
  cws_rsp_if.source                   rsp
);
  localparam int CAP = (COORD_BITS >= 16) ? 65535 : ((1 << COORD_BITS) - 1);

  cws_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ctrl      <= cws_pkg::RST_CTRL;
      cfg.min_size  <= cws_pkg::RST_MIN_SIZE;
      cfg.max_size  <= cws_pkg::RST_MAX_SIZE;
      cfg.base_size <= cws_pkg::RST_BASE_SIZE;
      cfg.size_inc  <= cws_pkg::RST_SIZE_INC;
      cfg.ratio_lo  <= cws_pkg::RST_ASPECT;
      cfg.ratio_hi  <= cws_pkg::RST_ASPECT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cws_pkg::CFG_CONTROL:    cfg.ctrl      <= cfg_data[2:0];
        cws_pkg::CFG_MIN_SIZE:   cfg.min_size  <= cfg_data;
        cws_pkg::CFG_MAX_SIZE:   cfg.max_size  <= cfg_data;
        cws_pkg::CFG_BASE_SIZE:  cfg.base_size <= cfg_data;
        cws_pkg::CFG_SIZE_INC:   cfg.size_inc  <= cfg_data;
        cws_pkg::CFG_MIN_ASPECT: cfg.ratio_lo  <= cfg_data;
        cws_pkg::CFG_MAX_ASPECT: cfg.ratio_hi  <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: move whenever the response slot is free or being taken
  logic en;
  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  cws_pkg::item_t in_item;
  always_comb begin
    in_item.w    = cws_pkg::XW'(req.req_width);
    in_item.h    = cws_pkg::XW'(req.req_height);
    in_item.w0   = req.req_width;
    in_item.h0   = req.req_height;
    in_item.keep = req.keep_x;
    in_item.rnd  = req.round_nearest;
    in_item.lw   = req.limit_width;
    in_item.lh   = req.limit_height;
  end

  logic           v_min, v_max;
  cws_pkg::item_t i_min, i_max;

  cws_aspect #(.IS_MAX(1'b0)) u_asp_min (
    .clk(clk), .rst(rst), .en(en), .cfg(cfg),
    .in_valid(req.valid), .in_item(in_item),
    .out_valid(v_min), .out_item(i_min)
  );

  cws_aspect #(.IS_MAX(1'b1)) u_asp_max (
    .clk(clk), .rst(rst), .en(en), .cfg(cfg),
    .in_valid(v_min), .in_item(i_min),
    .out_valid(v_max), .out_item(i_max)
  );

  cws_snap #(.COORD_BITS(COORD_BITS)) u_snap (
    .clk(clk), .rst(rst), .en(en), .cfg(cfg),
    .in_valid(v_max), .in_item(i_max),
    .out_valid(rsp.valid), .out_width(rsp.out_width), .out_height(rsp.out_height)
  );

  a_floor: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.out_width != 16'd0) && (rsp.out_height != 16'd0))
    else $error("response side below 1");

  a_cap: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.out_width <= 16'(CAP)) && (rsp.out_height <= 16'(CAP)))
    else $error("response side above coordinate cap");

  a_flush: assert property (@(posedge clk) rst |=> !rsp.valid)
    else $error("response valid straight after reset");

endmodule
